// ===== rtl/ale_pkg.sv =====
package ale_pkg;

  localparam int ALE_CAPACITY   = 128;
  localparam int ALE_DATA_WIDTH = 32;

  typedef enum logic [2:0] {
    OP_GET    = 3'd0,
    OP_INSERT = 3'd1,
    OP_DELETE = 3'd2,
    OP_PRIOR  = 3'd3,
    OP_NEXT   = 3'd4,
    OP_CLEAR  = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_BAD_POS   = 2'd1,
    STAT_FULL      = 2'd2,
    STAT_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_WALK,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic    valid;
    status_t status;
  } done_t;

endpackage

// ===== rtl/ale_store.sv =====
module ale_store #(
  parameter int DEPTH = 128,
  parameter int DW    = 32,
  parameter int AW    = 7
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/ale_ctrl.sv =====
module ale_ctrl
  import ale_pkg::*;
#(
  parameter int CAPACITY   = ALE_CAPACITY,
  parameter int DATA_WIDTH = ALE_DATA_WIDTH,
  parameter int AW         = $clog2(CAPACITY),
  parameter int CW         = $clog2(CAPACITY + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [2:0]            opcode,
  input  logic [7:0]            position,
  input  logic [DATA_WIDTH-1:0] value,
  output logic                  busy,
  output done_t                 done,
  output logic [DATA_WIDTH-1:0] result,
  output logic [CW-1:0]         cnt_next,
  output logic                  mem_we,
  output logic [AW-1:0]         mem_waddr,
  output logic [DATA_WIDTH-1:0] mem_wdata,
  output logic                  mem_re,
  output logic [AW-1:0]         mem_raddr,
  input  logic [DATA_WIDTH-1:0] mem_rdata
);

  localparam int XW = ((CW > 8) ? CW : 8) + 1;

  state_t                state_r, state_nxt;
  op_t                   op_r, op_nxt;
  logic [7:0]            pos_r, pos_nxt;
  logic [DATA_WIDTH-1:0] val_r, val_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [CW-1:0]         rem_r, rem_nxt;
  logic [AW-1:0]         rd_addr_r, rd_addr_nxt;
  logic                  pend_r, pend_nxt;
  logic [AW-1:0]         pend_addr_r, pend_addr_nxt;
  logic                  found_r, found_nxt;
  logic [DATA_WIDTH-1:0] prev_r, prev_nxt;
  logic [DATA_WIDTH-1:0] result_r, result_nxt;
  status_t               status_r, status_nxt;

  logic [XW-1:0] pos_x;
  logic [XW-1:0] cnt_x;
  logic [AW-1:0] pos_idx;
  logic          pos_bad;
  logic          ins_bad;
  logic          is_full;
  logic          last_elem;

  assign pos_x     = XW'(pos_r);
  assign cnt_x     = XW'(cnt_r);
  assign pos_idx   = AW'(pos_r - 8'd1);
  assign pos_bad   = (pos_r == 8'd0) || (pos_x > cnt_x);
  assign ins_bad   = (pos_r == 8'd0) || (pos_x > cnt_x + XW'(1));
  assign is_full   = cnt_x >= XW'(CAPACITY);
  assign last_elem = ((CW + 1)'(pend_addr_r) + (CW + 1)'(1)) >= (CW + 1)'(cnt_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      pend_r  <= 1'b0;
      found_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      pend_r  <= pend_nxt;
      found_r <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    pos_r       <= pos_nxt;
    val_r       <= val_nxt;
    rem_r       <= rem_nxt;
    rd_addr_r   <= rd_addr_nxt;
    pend_addr_r <= pend_addr_nxt;
    prev_r      <= prev_nxt;
    result_r    <= result_nxt;
    status_r    <= status_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    pos_nxt       = pos_r;
    val_nxt       = val_r;
    cnt_nxt       = cnt_r;
    rem_nxt       = rem_r;
    rd_addr_nxt   = rd_addr_r;
    pend_nxt      = pend_r;
    pend_addr_nxt = pend_addr_r;
    found_nxt     = found_r;
    prev_nxt      = prev_r;
    result_nxt    = result_r;
    status_nxt    = status_r;
    mem_we        = 1'b0;
    mem_waddr     = pend_addr_r;
    mem_wdata     = mem_rdata;
    mem_re        = 1'b0;
    mem_raddr     = rd_addr_r;
    done          = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          op_nxt     = op_t'(opcode);
          pos_nxt    = position;
          val_nxt    = value;
          status_nxt = STAT_OK;
          result_nxt = '0;
          found_nxt  = 1'b0;
          pend_nxt   = 1'b0;
          state_nxt  = ST_CHECK;
        end
      end

      ST_CHECK: begin
        state_nxt = ST_FINISH;
        unique case (op_r)
          OP_GET: begin
            if (pos_bad) begin
              status_nxt = STAT_BAD_POS;
            end else begin
              rd_addr_nxt = pos_idx;
              rem_nxt     = CW'(1);
              state_nxt   = ST_WALK;
            end
          end
          OP_INSERT: begin
            if (ins_bad) begin
              status_nxt = STAT_BAD_POS;
            end else if (is_full) begin
              status_nxt = STAT_FULL;
            end else begin
              rd_addr_nxt = AW'(cnt_r - CW'(1));
              rem_nxt     = CW'(cnt_x - pos_x + XW'(1));
              state_nxt   = ST_WALK;
            end
          end
          OP_DELETE: begin
            if (pos_bad) begin
              status_nxt = STAT_BAD_POS;
            end else begin
              rd_addr_nxt = pos_idx;
              rem_nxt     = CW'(cnt_x - pos_x + XW'(1));
              state_nxt   = ST_WALK;
            end
          end
          OP_PRIOR, OP_NEXT: begin
            rd_addr_nxt = '0;
            rem_nxt     = cnt_r;
            state_nxt   = ST_WALK;
          end
          OP_CLEAR: begin
            state_nxt = ST_FINISH;
          end
          default: begin
            state_nxt = ST_FINISH;
          end
        endcase
      end

      ST_WALK: begin
        // one read issued per cycle; the store registers the read data, which is back in the next cycle
        if (rem_r != '0) begin
          mem_re        = 1'b1;
          pend_nxt      = 1'b1;
          pend_addr_nxt = rd_addr_r;
          rem_nxt       = rem_r - CW'(1);
          rd_addr_nxt   = (op_r == OP_INSERT) ? rd_addr_r - AW'(1) : rd_addr_r + AW'(1);
        end else begin
          pend_nxt = 1'b0;
        end

        if (pend_r) begin
          unique case (op_r)
            OP_GET: begin
              result_nxt = mem_rdata;
              state_nxt  = ST_FINISH;
            end
            OP_INSERT: begin
              mem_we    = 1'b1;
              mem_waddr = pend_addr_r + AW'(1);
            end
            OP_DELETE: begin
              if (pend_addr_r == pos_idx) begin
                result_nxt = mem_rdata;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = pend_addr_r - AW'(1);
              end
            end
            OP_PRIOR, OP_NEXT: begin
              prev_nxt = mem_rdata;
              if (found_r) begin
                result_nxt = mem_rdata;
                state_nxt  = ST_FINISH;
              end else if (mem_rdata == val_r) begin
                if (op_r == OP_PRIOR) begin
                  if (pend_addr_r == '0) begin
                    status_nxt = STAT_NOT_FOUND;
                  end else begin
                    result_nxt = prev_r;
                  end
                  state_nxt = ST_FINISH;
                end else if (last_elem) begin
                  status_nxt = STAT_NOT_FOUND;
                  state_nxt  = ST_FINISH;
                end else begin
                  found_nxt = 1'b1;
                end
              end
            end
            default: begin
              state_nxt = ST_FINISH;
            end
          endcase
        end else if (rem_r == '0) begin
          if (op_r == OP_PRIOR || op_r == OP_NEXT) begin
            status_nxt = STAT_NOT_FOUND;
          end
          state_nxt = ST_FINISH;
        end
      end

      ST_FINISH: begin
        done.valid  = 1'b1;
        done.status = status_r;
        pend_nxt    = 1'b0;
        state_nxt   = ST_IDLE;
        if (status_r == STAT_OK) begin
          unique case (op_r)
            OP_INSERT: begin
              mem_we    = 1'b1;
              mem_waddr = pos_idx;
              mem_wdata = val_r;
              cnt_nxt   = cnt_r + CW'(1);
            end
            OP_DELETE: begin
              cnt_nxt = cnt_r - CW'(1);
            end
            OP_CLEAR: begin
              cnt_nxt = '0;
            end
            default: begin
              cnt_nxt = cnt_r;
            end
          endcase
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy     = (state_r != ST_IDLE);
  assign result   = result_r;
  assign cnt_next = cnt_nxt;

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(CAPACITY))
    else $error("element count beyond capacity");

  a_start_check: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (state_r == ST_CHECK))
    else $error("accepted transaction not decoded");

  a_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == ST_WALK || state_r == ST_FINISH))
    else $error("store written outside walk or finish");

  a_full_no_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FINISH && op_r == OP_INSERT && status_r == STAT_FULL)
      |=> (cnt_r == $past(cnt_r)))
    else $error("full list grew");
`endif

endmodule

// ===== rtl/array_list_engine.sv =====
// Ordered list of up to CAPACITY values held in a single-port-read store. A
// transaction is taken when start is high and busy is low; busy stays high
// until its result has been produced. Clear, the spare opcodes and rejected
// requests go from the decode state ST_CHECK straight to ST_FINISH; get makes
// one store read in ST_WALK first; insert, delete and value search walk their
// elements in ST_WALK (up to the list length), since every element passes
// through the store's one read port, one a cycle; out_valid is registered from
// ST_FINISH. The next transaction can be taken in the cycle in which out_valid
// is high. Each result is shown for exactly one cycle with out_valid high and
// cannot be held off by the receiver, so it has to be captured in that cycle.
module array_list_engine
  import ale_pkg::*;
#(
  parameter int CAPACITY   = ALE_CAPACITY,
  parameter int DATA_WIDTH = ALE_DATA_WIDTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_opcode,
  input  logic [7:0]  in_position,
  input  logic [31:0] in_item_value,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [31:0] out_result_value,
  output logic [7:0]  out_list_length,
  output logic        out_list_empty
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  done_t                 done;
  logic [DATA_WIDTH-1:0] result;
  logic [CW-1:0]         cnt_next;
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [DATA_WIDTH-1:0] mem_wdata;
  logic                  mem_re;
  logic [AW-1:0]         mem_raddr;
  logic [DATA_WIDTH-1:0] mem_rdata;

  logic        out_valid_r;
  logic [1:0]  out_status_r;
  logic [31:0] out_result_value_r;
  logic [7:0]  out_list_length_r;
  logic        out_list_empty_r;

  ale_ctrl #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH),
    .AW         (AW),
    .CW         (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .opcode    (in_opcode),
    .position  (in_position),
    .value     (DATA_WIDTH'(in_item_value)),
    .busy      (busy),
    .done      (done),
    .result    (result),
    .cnt_next  (cnt_next),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  ale_store #(
    .DEPTH (CAPACITY),
    .DW    (DATA_WIDTH),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= done.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (done.valid) begin
      out_status_r       <= done.status;
      out_result_value_r <= 32'(result);
      out_list_length_r  <= 8'(cnt_next);
      out_list_empty_r   <= (cnt_next == '0);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_result_value = out_result_value_r;
  assign out_list_length  = out_list_length_r;
  assign out_list_empty   = out_list_empty_r;

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import ale_pkg::*;

  localparam int TOTAL_ITEMS  = 650;
  localparam int CYCLE_LIMIT  = 900_000;
  localparam int DRAIN_LIMIT  = 2_000;
  localparam int TAIL_CYCLES  = ALE_CAPACITY + 20;
  localparam int ROW_COUNT    = 25;

  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;

  typedef struct packed {
    status_t     status;
    logic [31:0] value;
    logic [7:0]  length;
    logic        empty;
  } list_reply_t;

  typedef struct packed {
    logic [2:0]  op;
    logic [7:0]  pos;
    logic [31:0] val;
    logic        typed;
    list_reply_t want;
  } request_row_t;

  typedef enum {
    MODE_FILL,
    MODE_HOLD,
    MODE_DRAIN,
    MODE_MIX
  } traffic_mode_t;

  localparam list_reply_t NO_REPLY = '{STAT_OK, 32'd0, 8'd0, 1'b0};

  localparam logic [31:0] VALUE_POOL [6] = '{
    32'h0000_0000, 32'h0000_0001, 32'h8000_0000,
    32'hFFFF_FFFF, 32'h5555_AAAA, 32'h0000_0042
  };

  // empty-list errors, build a short list, then read, search, try the spare opcodes, trim and clear it
  localparam request_row_t DIRECTED_ROWS [ROW_COUNT] = '{
    '{OP_GET,     8'd1,   32'd0,         1'b1, '{STAT_BAD_POS,   32'd0, 8'd0, 1'b1}},
    '{OP_DELETE,  8'd0,   32'd0,         1'b1, '{STAT_BAD_POS,   32'd0, 8'd0, 1'b1}},
    '{OP_INSERT,  8'd2,   32'd7,         1'b1, '{STAT_BAD_POS,   32'd0, 8'd0, 1'b1}},
    '{OP_INSERT,  8'd0,   32'd7,         1'b1, '{STAT_BAD_POS,   32'd0, 8'd0, 1'b1}},
    '{OP_PRIOR,   8'd0,   32'd0,         1'b1, '{STAT_NOT_FOUND, 32'd0, 8'd0, 1'b1}},
    '{OP_NEXT,    8'd255, 32'hFFFF_FFFF, 1'b1, '{STAT_NOT_FOUND, 32'd0, 8'd0, 1'b1}},
    '{OP_INSERT,  8'd1,   32'hFFFF_FFFF, 1'b1, '{STAT_OK,        32'd0, 8'd1, 1'b0}},
    '{OP_INSERT,  8'd1,   32'h0000_0000, 1'b1, '{STAT_OK,        32'd0, 8'd2, 1'b0}},
    '{OP_INSERT,  8'd3,   32'hA5A5_5A5A, 1'b1, '{STAT_OK,        32'd0, 8'd3, 1'b0}},
    '{OP_INSERT,  8'd2,   32'h1234_5678, 1'b1, '{STAT_OK,        32'd0, 8'd4, 1'b0}},
    '{OP_GET,     8'd1,   32'd0,         1'b1, '{STAT_OK,        32'd0, 8'd4, 1'b0}},
    '{OP_GET,     8'd4,   32'd0,         1'b1, '{STAT_OK,  32'hA5A5_5A5A, 8'd4, 1'b0}},
    '{OP_GET,     8'd5,   32'd0,         1'b1, '{STAT_BAD_POS,   32'd0, 8'd4, 1'b0}},
    '{OP_GET,     8'd255, 32'd0,         1'b1, '{STAT_BAD_POS,   32'd0, 8'd4, 1'b0}},
    '{OP_PRIOR,   8'd0,   32'h0000_0000, 1'b1, '{STAT_NOT_FOUND, 32'd0, 8'd4, 1'b0}},
    '{OP_PRIOR,   8'd0,   32'hFFFF_FFFF, 1'b0, NO_REPLY},
    '{OP_NEXT,    8'd0,   32'hA5A5_5A5A, 1'b1, '{STAT_NOT_FOUND, 32'd0, 8'd4, 1'b0}},
    '{OP_NEXT,    8'd0,   32'h0000_0000, 1'b0, NO_REPLY},
    '{OP_NEXT,    8'd9,   32'hDEAD_BEEF, 1'b1, '{STAT_NOT_FOUND, 32'd0, 8'd4, 1'b0}},
    '{OP_SPARE_6, 8'd1,   32'hFFFF_FFFF, 1'b1, '{STAT_OK,        32'd0, 8'd4, 1'b0}},
    '{OP_SPARE_7, 8'd255, 32'd0,         1'b1, '{STAT_OK,        32'd0, 8'd4, 1'b0}},
    '{OP_DELETE,  8'd2,   32'd0,         1'b0, NO_REPLY},
    '{OP_DELETE,  8'd4,   32'd0,         1'b1, '{STAT_BAD_POS,   32'd0, 8'd3, 1'b0}},
    '{OP_CLEAR,   8'd0,   32'd0,         1'b1, '{STAT_OK,        32'd0, 8'd0, 1'b1}},
    '{OP_DELETE,  8'd1,   32'd0,         1'b1, '{STAT_BAD_POS,   32'd0, 8'd0, 1'b1}}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  in_opcode = 3'd0;
  logic [7:0]  in_position = 8'd0;
  logic [31:0] in_item_value = 32'd0;
  logic        out_valid;
  logic [1:0]  out_status;
  logic [31:0] out_result_value;
  logic [7:0]  out_list_length;
  logic        out_list_empty;

  logic [31:0] shadow_list [ALE_CAPACITY];
  int          shadow_count = 0;
  list_reply_t awaited_replies [$];
  list_reply_t due_reply;
  int          mismatch_count = 0;
  int          cycle_count = 0;
  int          issued = 0;
  int          burst_left = 1;
  bit          start_held = 1'b0;

  array_list_engine u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_opcode        (in_opcode),
    .in_position      (in_position),
    .in_item_value    (in_item_value),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_result_value (out_result_value),
    .out_list_length  (out_list_length),
    .out_list_empty   (out_list_empty)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  task automatic report_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycle_count, what);
    mismatch_count++;
  endtask

  task automatic predict_reply(input logic [2:0] op, input logic [7:0] pos,
                               input logic [31:0] val, output list_reply_t reply);
    int p;
    int hit;
    int j;
    p = int'(pos);
    hit = 0;
    while (hit < shadow_count && shadow_list[hit] != val) hit++;
    reply = NO_REPLY;
    case (op)
      OP_GET: begin
        if (p < 1 || p > shadow_count) reply.status = STAT_BAD_POS;
        else reply.value = shadow_list[p - 1];
      end
      OP_INSERT: begin
        if (p < 1 || p > shadow_count + 1) begin
          reply.status = STAT_BAD_POS;
        end else if (shadow_count >= ALE_CAPACITY) begin
          reply.status = STAT_FULL;
        end else begin
          for (j = shadow_count; j >= p; j--) shadow_list[j] = shadow_list[j - 1];
          shadow_list[p - 1] = val;
          shadow_count++;
        end
      end
      OP_DELETE: begin
        if (p < 1 || p > shadow_count) begin
          reply.status = STAT_BAD_POS;
        end else begin
          reply.value = shadow_list[p - 1];
          for (j = p; j < shadow_count; j++) shadow_list[j - 1] = shadow_list[j];
          shadow_count--;
        end
      end
      OP_PRIOR: begin
        if (hit >= shadow_count || hit == 0) reply.status = STAT_NOT_FOUND;
        else reply.value = shadow_list[hit - 1];
      end
      OP_NEXT: begin
        if (hit + 1 >= shadow_count) reply.status = STAT_NOT_FOUND;
        else reply.value = shadow_list[hit + 1];
      end
      OP_CLEAR: begin
        shadow_count = 0;
      end
      default: ;
    endcase
    reply.length = 8'(shadow_count);
    reply.empty  = (shadow_count == 0);
  endtask

  // one transaction; the sender idles between bursts
  task automatic send_request(input logic [2:0] op, input logic [7:0] pos,
                              input logic [31:0] val, input logic typed,
                              input list_reply_t typed_reply);
    list_reply_t reply;
    int gap;
    start         <= 1'b1;
    in_opcode     <= op;
    in_position   <= pos;
    in_item_value <= val;
    start_held    = 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    predict_reply(op, pos, val, reply);
    awaited_replies.push_back(typed ? typed_reply : reply);
    issued++;
    burst_left--;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                : $urandom_range(1, 8);
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 150)
                                         : $urandom_range(1, 6);
      start      <= 1'b0;
      start_held = 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic [7:0] pick_position(input int span);
    int r;
    r = $urandom_range(0, 99);
    if (span > 0 && r < 85) return 8'($urandom_range(1, span));
    if (r < 90) return 8'd0;
    if (r < 95) return 8'($urandom_range(span + 1, 255));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [31:0] pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return VALUE_POOL[$urandom_range(0, 5)];
    if (r < 7 && shadow_count > 0) return shadow_list[$urandom_range(0, shadow_count - 1)];
    return $urandom;
  endfunction

  task automatic pick_request(input traffic_mode_t mode, output logic [2:0] op,
                              output logic [7:0] pos, output logic [31:0] val);
    int r;
    logic [2:0] spare;
    r = $urandom_range(0, 99);
    spare = r[0] ? OP_SPARE_7 : OP_SPARE_6;
    case (mode)
      MODE_FILL:
        op = r < 85 ? OP_INSERT : r < 88 ? OP_GET : r < 91 ? OP_DELETE :
             r < 94 ? OP_PRIOR : r < 97 ? OP_NEXT : spare;
      MODE_HOLD:
        op = r < 30 ? OP_INSERT : r < 50 ? OP_GET : r < 55 ? OP_DELETE :
             r < 75 ? OP_PRIOR : r < 95 ? OP_NEXT : spare;
      MODE_DRAIN:
        op = r < 80 ? OP_DELETE : r < 85 ? OP_GET : r < 90 ? OP_PRIOR :
             r < 95 ? OP_NEXT : r < 98 ? OP_INSERT : spare;
      default:
        op = r < 3 ? OP_CLEAR : r < 7 ? spare : 3'($urandom_range(0, 4));
    endcase
    case (op)
      OP_INSERT:         pos = pick_position(shadow_count + 1);
      OP_GET, OP_DELETE: pos = pick_position(shadow_count);
      default:           pos = 8'($urandom_range(0, 255));
    endcase
    if (op == OP_INSERT || op == OP_PRIOR || op == OP_NEXT) val = pick_value();
    else val = $urandom;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (awaited_replies.size() == 0) begin
        report_mismatch("result with no transaction outstanding");
      end else begin
        due_reply = awaited_replies.pop_front();
        if (out_status !== due_reply.status)
          report_mismatch($sformatf("status %0d, wanted %0d", out_status, due_reply.status));
        if (out_result_value !== due_reply.value)
          report_mismatch($sformatf("value %h, wanted %h", out_result_value, due_reply.value));
        if (out_list_length !== due_reply.length)
          report_mismatch($sformatf("length %0d, wanted %0d", out_list_length,
                                    due_reply.length));
        if (out_list_empty !== due_reply.empty)
          report_mismatch($sformatf("empty %b, wanted %b", out_list_empty, due_reply.empty));
      end
    end
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("FAILURE");
    $finish;
  end

  initial begin
    traffic_mode_t mode;
    int phase_left;
    int waited;
    logic [2:0] op;
    logic [7:0] pos;
    logic [31:0] val;
    mode = MODE_FILL;
    phase_left = 0;
    waited = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    foreach (DIRECTED_ROWS[i])
      send_request(DIRECTED_ROWS[i].op, DIRECTED_ROWS[i].pos, DIRECTED_ROWS[i].val,
                   DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
    // fill to capacity, sit at full, drain, then mixed traffic, repeating until all items are issued
    while (issued < TOTAL_ITEMS) begin
      pick_request(mode, op, pos, val);
      send_request(op, pos, val, 1'b0, NO_REPLY);
      case (mode)
        MODE_FILL: begin
          if (shadow_count == ALE_CAPACITY) begin
            mode = MODE_HOLD;
            phase_left = 20;
          end
        end
        MODE_HOLD: begin
          phase_left--;
          if (phase_left == 0) mode = MODE_DRAIN;
        end
        MODE_DRAIN: begin
          if (shadow_count <= 1) begin
            mode = MODE_MIX;
            phase_left = 40;
          end
        end
        default: begin
          phase_left--;
          if (phase_left == 0) mode = MODE_FILL;
        end
      endcase
    end
    if (start_held) start <= 1'b0;
    while (awaited_replies.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (awaited_replies.size() != 0)
      report_mismatch($sformatf("%0d transactions never answered", awaited_replies.size()));
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
